[rtl/pf_pkg.sv]
package pf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CNT_W   = $clog2(VALUE_W);
  localparam int unsigned STAT_W  = 2;

  localparam logic [STAT_W-1:0] STATUS_COMPOSITE = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_PRIME     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_SMALL = 2'd2;

  localparam logic [VALUE_W-1:0] FIRST_DIVISOR = VALUE_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } pf_state_t;

endpackage

[rtl/prime_factorization.sv]
// Prime factorization by trial division. One 32-bit unsigned value per input item;
// its prime factors come out in non-decreasing order, one item each, the final one
// with out_tlast set. out_tuser gives the status: 0 factor of a composite, 1 the
// value is prime (factor equals the value), 2 the value is below 2 (factor 0).
// Items are handled one at a time: in_tready is low from acceptance until the final
// result has been taken. Each trial divisor costs one pass of the shared bit-serial
// divider (start, one restoring step per quotient bit, decision), plus the output
// handshake for each factor. The number of passes is about the square root of the
// largest remaining cofactor, so a 32-bit prime takes up to about 65536 passes.
module prime_factorization import pf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [VALUE_W-1:0]   in_tdata,   // [31:0] value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [VALUE_W-1:0]   out_tdata,  // [31:0] factor
  output logic [STAT_W-1:0]    out_tuser,  // [1:0] status
  output logic                 out_tlast
);

  pf_state_t          state_r, state_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [VALUE_W-1:0] dvs_r, dvs_nxt;
  logic               found_r, found_nxt;
  logic               cont_r, cont_nxt;
  logic               start_r, start_nxt;
  logic               ovld_r, ovld_nxt;
  logic [VALUE_W-1:0] ofac_r, ofac_nxt;
  logic [STAT_W-1:0]  ostat_r, ostat_nxt;
  logic               olast_r, olast_nxt;

  logic               div_done;
  logic [VALUE_W-1:0] div_quo;
  logic [VALUE_W-1:0] div_rem;

  pf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (rem_r),
    .divisor   (dvs_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    found_nxt = found_r;
    cont_nxt  = cont_r;
    start_nxt = 1'b0;
    ovld_nxt  = ovld_r;
    ofac_nxt  = ofac_r;
    ostat_nxt = ostat_r;
    olast_nxt = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          value_nxt = in_tdata;
          rem_nxt   = in_tdata;
          dvs_nxt   = FIRST_DIVISOR;
          found_nxt = 1'b0;
          if (in_tdata < FIRST_DIVISOR) begin
            ofac_nxt  = '0;
            ostat_nxt = STATUS_TOO_SMALL;
            olast_nxt = 1'b1;
            ovld_nxt  = 1'b1;
            cont_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end else begin
            start_nxt = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (dvs_r > div_quo) begin
            // divisor squared exceeds remainder
            ofac_nxt  = found_r ? rem_r : value_r;
            ostat_nxt = found_r ? STATUS_COMPOSITE : STATUS_PRIME;
            olast_nxt = 1'b1;
            ovld_nxt  = 1'b1;
            cont_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end else if (div_rem == '0) begin
            ofac_nxt  = dvs_r;
            ostat_nxt = STATUS_COMPOSITE;
            olast_nxt = (div_quo == VALUE_W'(1));
            ovld_nxt  = 1'b1;
            cont_nxt  = (div_quo != VALUE_W'(1));
            rem_nxt   = div_quo;
            found_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            dvs_nxt   = dvs_r + VALUE_W'(1);
            start_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          ovld_nxt = 1'b0;
          if (cont_r) begin
            start_nxt = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    found_r <= found_nxt;
    cont_r  <= cont_nxt;
    ofac_r  <= ofac_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = ofac_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

endmodule

[rtl/pf_div.sv]
module pf_div import pf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [VALUE_W-1:0] divisor,
  output logic               done,
  output logic [VALUE_W-1:0] quotient,
  output logic [VALUE_W-1:0] remainder
);

  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [VALUE_W:0]   trial;
  logic [VALUE_W:0]   diff;

  // one restoring step per cycle
  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(VALUE_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[VALUE_W]) begin
        rem_nxt = diff[VALUE_W-1:0];
        quo_nxt = {quo_r[VALUE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VALUE_W-1:0];
        quo_nxt = {quo_r[VALUE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[dv/testbench.sv]
module testbench;
  import pf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned RANDOM_VALUES = 100;
  localparam int unsigned HOLD_AFTER = 40;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned PAUSE_AT = 60;

  typedef struct {
    logic [VALUE_W-1:0] factor;
    logic [STAT_W-1:0]  status;
    logic               last;
  } factor_item_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic [VALUE_W-1:0] factor;
    logic [STAT_W-1:0]  status;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;
  logic [STAT_W-1:0]  out_tuser;
  logic               out_tlast;

  factor_item_t pending_factors[$];
  probe_t       probes[$];
  int unsigned  mismatches = 0;
  int unsigned  values_sent = 0;
  int unsigned  cycles = 0;
  int           burst_left = 0;

  prime_factorization dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d factors outstanding", cycles,
               pending_factors.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // trial division, smallest divisor first; every divisor that hits is prime
  function automatic void factorize(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] divisor;
    factor_item_t       found[$];
    factor_item_t       r;
    if (value < FIRST_DIVISOR) begin
      r = '{factor: '0, status: STATUS_TOO_SMALL, last: 1'b1};
      pending_factors.push_back(r);
      return;
    end
    rest = value;
    divisor = FIRST_DIVISOR;
    while (rest > 1 && divisor <= rest / divisor) begin
      if (rest % divisor == 0) begin
        r = '{factor: divisor, status: STATUS_COMPOSITE, last: 1'b0};
        found.push_back(r);
        rest = rest / divisor;
      end else begin
        divisor = divisor + 1;
      end
    end
    if (found.size() == 0) begin
      r = '{factor: value, status: STATUS_PRIME, last: 1'b1};
      found.push_back(r);
    end else if (rest > 1) begin
      r = '{factor: rest, status: STATUS_COMPOSITE, last: 1'b0};
      found.push_back(r);
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[i]) pending_factors.push_back(found[i]);
  endfunction

  function automatic probe_t probe(input logic [VALUE_W-1:0] value, input bit typed,
                                   input logic [VALUE_W-1:0] factor,
                                   input logic [STAT_W-1:0] status);
    probe_t p;
    p = '{value: value, typed: typed, factor: factor, status: status};
    return p;
  endfunction

  // mostly small or smooth values so that trial division stays short
  function automatic logic [VALUE_W-1:0] pick_value();
    longint unsigned product;
    int unsigned     f;
    int unsigned     kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return VALUE_W'($urandom_range(0, 3));
    if (kind <= 4) return VALUE_W'($urandom_range(2, 65535));
    if (kind <= 6) return VALUE_W'($urandom_range(1, 4095)) << $urandom_range(0, 20);
    product = 1;
    repeat ($urandom_range(2, 14)) begin
      f = $urandom_range(2, 251);
      if (product * 64'(f) <= 64'hFFFF_FFFF) product = product * 64'(f);
    end
    return VALUE_W'(product);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic offer(input probe_t p);
    factor_item_t r;
    in_tvalid <= 1'b1;
    in_tdata <= p.value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (p.typed) begin
      r = '{factor: p.factor, status: p.status, last: 1'b1};
      pending_factors.push_back(r);
    end else begin
      factorize(p.value);
    end
    values_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
    end
  endtask

  always @(posedge clk) begin
    factor_item_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_factors.size() == 0) begin
        note_mismatch($sformatf("unexpected item factor=%0d status=%0d last=%0b",
                                out_tdata, out_tuser, out_tlast));
      end else begin
        e = pending_factors.pop_front();
        if (out_tdata !== e.factor || out_tuser !== e.status || out_tlast !== e.last)
          note_mismatch($sformatf("expected factor=%0d status=%0d last=%0b, got %0d %0d %0b",
                                  e.factor, e.status, e.last, out_tdata, out_tuser,
                                  out_tlast));
      end
    end
  end

  // receiver: phases of always-ready, a fixed stall pattern and random stalls,
  // plus one long hold-off that backs the block up into its input
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    int unsigned mode;
    int unsigned phase_left;
    logic [31:0] pattern;
    hold_left = 0;
    hold_done = 1'b0;
    mode = 0;
    phase_left = 0;
    pattern = '1;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && values_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 2);
          phase_left = $urandom_range(20, 200);
          pattern = $urandom;
        end
        phase_left--;
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= pattern[phase_left[4:0]];
          end
          default: begin
            out_tready <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  initial begin
    probes.push_back(probe(32'd0, 1'b1, 32'd0, STATUS_TOO_SMALL));
    probes.push_back(probe(32'd1, 1'b1, 32'd0, STATUS_TOO_SMALL));
    probes.push_back(probe(32'd2, 1'b1, 32'd2, STATUS_PRIME));
    probes.push_back(probe(32'd3, 1'b1, 32'd3, STATUS_PRIME));
    probes.push_back(probe(32'd4, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd6, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd8, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd9, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd12, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd49, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd97, 1'b1, 32'd97, STATUS_PRIME));
    probes.push_back(probe(32'd65521, 1'b1, 32'd65521, STATUS_PRIME));
    probes.push_back(probe(32'd65537, 1'b1, 32'd65537, STATUS_PRIME));
    probes.push_back(probe(32'd1000003, 1'b1, 32'd1000003, STATUS_PRIME));
    probes.push_back(probe(32'd131074, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd1022117, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'h8000_0000, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'hFFFF_FFFF, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'hAAAA_AAAA, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'h5555_5555, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'hFFFE_0001, 1'b0, '0, STATUS_COMPOSITE));
    probes.push_back(probe(32'd0, 1'b1, 32'd0, STATUS_TOO_SMALL));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 5);

    foreach (probes[i]) offer(probes[i]);

    for (int unsigned n = 0; n < RANDOM_VALUES; n++) begin
      if (n == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        wait (pending_factors.size() == 0);
        @(posedge clk);
      end
      offer(probe(pick_value(), 1'b0, '0, STATUS_COMPOSITE));
    end

    in_tvalid <= 1'b0;
    wait (pending_factors.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_factors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
